[hw/rtl/lppp_pkg.sv]
// ----------------------------------------------------------------------------
// lppp_pkg
// shared types and constants for the lidar point to pixel projection block
// ----------------------------------------------------------------------------
package lppp_pkg;

	localparam int IMAGE_WIDTH_DEF  = 1920;
	localparam int IMAGE_HEIGHT_DEF = 1080;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int NUM_REGS   = 6;
	localparam int ADDR_W     = 6;
	localparam int PIX_W      = 11;

	typedef enum logic [2:0] {
		REG_R0_C01 = 3'd0,
		REG_R0_C23 = 3'd1,
		REG_R1_C01 = 3'd2,
		REG_R1_C23 = 3'd3,
		REG_R2_C01 = 3'd4,
		REG_R2_C23 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_col;
		logic [PIX_W-1:0]   pixel_row;
		logic signed [31:0] point_depth;
		logic               in_frame;
	} pixel_t;

	// divider status
	typedef struct packed {
		logic zero;
		logic ovf;
		logic neg;
	} div_flags_t;

endpackage

[hw/rtl/lppp_div.sv]
// ----------------------------------------------------------------------------
// lppp_div
// pipelined restoring divider, one quotient bit per stage, small quotients
// ----------------------------------------------------------------------------
module lppp_div #(
	parameter int SW = 50,
	parameter int QW = 11
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [SW-1:0]      num,
	input  logic signed [SW-1:0]      den,
	output logic [QW-1:0]             quo,
	output lppp_pkg::div_flags_t      flags
);
	import lppp_pkg::*;

	localparam int RW = SW + QW + 1;

	logic [RW-1:0]   rem_s [QW+1];
	logic [RW-1:0]   den_s [QW+1];
	logic [QW-1:0]   quo_s [QW+1];
	div_flags_t      flg_s [QW+1];

	logic [SW-1:0] n_mag, d_mag;
	logic [RW-1:0] n_ext, d_ext;

	always_comb begin
		n_mag = num[SW-1] ? SW'(-num) : SW'(num);
		d_mag = den[SW-1] ? SW'(-den) : SW'(den);
		n_ext = RW'(n_mag);
		d_ext = RW'(d_mag);
	end

	// magnitudes, sign, zero divisor and quotient overflow
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]      <= n_ext;
			den_s[0]      <= d_ext;
			quo_s[0]      <= '0;
			flg_s[0].zero <= (den == '0);
			flg_s[0].neg  <= num[SW-1] ^ den[SW-1];
			flg_s[0].ovf  <= n_ext >= (d_ext << QW);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int K = QW - 1 - i;
		logic [RW-1:0] shd;
		logic          take;
		logic [QW-1:0] qn;
		always_comb begin
			shd   = den_s[i] << K;
			take  = rem_s[i] >= shd;
			qn    = quo_s[i];
			qn[K] = take;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - shd : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= qn;
				flg_s[i+1] <= flg_s[i];
			end
		end
	end

	assign quo   = quo_s[QW];
	assign flags = flg_s[QW];

endmodule

[hw/rtl/lidar_point_pixel_projection.sv]
// ----------------------------------------------------------------------------
// lidar_point_pixel_projection
// projects a lidar point through a 3x4 camera matrix onto an image pixel
// ----------------------------------------------------------------------------
// Takes one point per cycle while the output is not stalled and returns one
// pixel transaction per point, in order. The pipeline holds one stage of
// nine 32x32 multipliers, one stage of row sums, the divider front stage,
// one stage per quotient bit of the column and row dividers, with QW =
// clog2(max(IMAGE_WIDTH, IMAGE_HEIGHT) + 1), and the bounds check feeding
// the output register.
// The whole pipeline moves whenever the output register is empty or taken,
// so a stall holds every stage and nothing is lost or repeated.
// Matrix registers are 64 bits on an apb port at 8*index; write them only
// while no point is in flight.
module lidar_point_pixel_projection #(
	parameter int IMAGE_WIDTH  = lppp_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = lppp_pkg::IMAGE_HEIGHT_DEF,
	parameter int FRAC_BITS    = lppp_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// point transaction in
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lppp_pkg::point_t              in_data,
	// pixel transaction out
	output logic                          out_valid,
	input  logic                          out_ready,
	output lppp_pkg::pixel_t              out_data,
	// apb config
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lppp_pkg::ADDR_W-1:0]   paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready
);
	import lppp_pkg::*;

	// sum width: shifted products keep 64-FRAC_BITS bits, plus carry room
	localparam int SW   = 66 - FRAC_BITS;
	localparam int MAXD = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int QW   = $clog2(MAXD + 1);
	localparam int DL   = QW + 1;

	// ---------------- configuration registers ----------------
	logic [63:0] cfg_q [NUM_REGS];
	reg_idx_t    idx;
	logic        idx_ok;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign idx_ok = (32'(idx) < NUM_REGS);
	assign pready = 1'b1;
	assign prdata = idx_ok ? cfg_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
		end else if (psel && penable && pwrite && pready && idx_ok) begin
			cfg_q[idx] <= pwdata;
		end
	end

	// coefficient c of row r: high word is the even coefficient
	logic signed [31:0] coef [3][4];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			coef[r][0] = cfg_q[2*r][63:32];
			coef[r][1] = cfg_q[2*r][31:0];
			coef[r][2] = cfg_q[2*r+1][63:32];
			coef[r][3] = cfg_q[2*r+1][31:0];
		end
	end

	// ---------------- pipeline control ----------------
	// advance whenever the output slot is free or being drained
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	logic vld_s1, vld_s2;
	logic dvld_q [DL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			for (int i = 0; i < DL; i++) dvld_q[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			dvld_q[0] <= vld_s2;
			for (int i = 1; i < DL; i++) dvld_q[i] <= dvld_q[i-1];
			out_valid <= dvld_q[DL-1];
		end
	end

	// ---------------- stage 1: products ----------------
	logic signed [63:0] prod_s1  [3][3];
	logic signed [31:0] coef3_s1 [3];
	logic signed [31:0] depth_s1;
	logic signed [31:0] pt [3];

	assign pt[0] = in_data.point_x;
	assign pt[1] = in_data.point_y;
	assign pt[2] = in_data.point_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= coef[r][c] * pt[c];
				coef3_s1[r] <= coef[r][3];
			end
			depth_s1 <= in_data.point_z;
		end
	end

	// ---------------- stage 2: floor shift and row sums ----------------
	logic signed [SW-1:0] sum_s2 [3];
	logic signed [31:0]   depth_s2;
	logic signed [SW-1:0] sum_c  [3];

	always_comb begin
		logic signed [63:0] sh;
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = SW'(coef3_s1[r]);
			for (int c = 0; c < 3; c++) begin
				sh       = prod_s1[r][c] >>> FRAC_BITS;
				sum_c[r] = sum_c[r] + sh[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) sum_s2[r] <= sum_c[r];
			depth_s2 <= depth_s1;
		end
	end

	// ---------------- divider stages ----------------
	logic [QW-1:0] col_q, row_q;
	div_flags_t    col_f, row_f;

	lppp_div #(.SW(SW), .QW(QW)) u_div_col (
		.clk   (clk),
		.en    (adv),
		.num   (sum_s2[0]),
		.den   (sum_s2[2]),
		.quo   (col_q),
		.flags (col_f)
	);

	lppp_div #(.SW(SW), .QW(QW)) u_div_row (
		.clk   (clk),
		.en    (adv),
		.num   (sum_s2[1]),
		.den   (sum_s2[2]),
		.quo   (row_q),
		.flags (row_f)
	);

	// depth rides alongside the divider
	logic signed [31:0] depth_d_q [DL];
	always_ff @(posedge clk) begin
		if (adv) begin
			depth_d_q[0] <= depth_s2;
			for (int i = 1; i < DL; i++) depth_d_q[i] <= depth_d_q[i-1];
		end
	end

	// ---------------- bounds check and output register ----------------
	logic ok;
	always_comb begin
		logic col_ok, row_ok;
		// negative with nonzero magnitude is off image; (-1,0) truncates to 0
		col_ok = !col_f.ovf && (!col_f.neg || col_q == '0)
			&& ({1'b0, col_q} < (QW+1)'(IMAGE_WIDTH));
		row_ok = !row_f.ovf && (!row_f.neg || row_q == '0)
			&& ({1'b0, row_q} < (QW+1)'(IMAGE_HEIGHT));
		ok = !col_f.zero && col_ok && row_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.pixel_col   <= ok ? PIX_W'(col_q) : '0;
			out_data.pixel_row   <= ok ? PIX_W'(row_q) : '0;
			out_data.point_depth <= depth_d_q[DL-1];
			out_data.in_frame    <= ok;
		end
	end

endmodule

[hw/rtl/lppp_checker.sv]
// ----------------------------------------------------------------------------
// lppp_checker
// port level checks for the projection block, bound to the top level
// ----------------------------------------------------------------------------
module lppp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input lppp_pkg::pixel_t  out_data
);
	import lppp_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	// an empty output slot never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// off-frame results carry a zero pixel
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_frame |->
			out_data.pixel_col == '0 && out_data.pixel_row == '0)
		else $error("off-frame pixel not zero");

	// a stall toward the output stalls the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

bind lidar_point_pixel_projection lppp_checker u_lppp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[tb/lppp_scoreboard.sv]
// ----------------------------------------------------------------------------
// lppp_scoreboard
// predicts pixel transactions from point transactions and checks dut output
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class lppp_scoreboard;

	logic [63:0] proj_mat [lppp_pkg::NUM_REGS];
	lppp_pkg::pixel_t pixel_q [$];
	int unsigned mismatches;
	int unsigned img_w;
	int unsigned img_h;

	function new(int unsigned w, int unsigned h);
		img_w = w;
		img_h = h;
		mismatches = 0;
		foreach (proj_mat[i]) proj_mat[i] = '0;
	endfunction

	function void set_reg(int unsigned idx, logic [63:0] val);
		if (idx < lppp_pkg::NUM_REGS) proj_mat[idx] = val;
	endfunction

	function longint coef(int r, int c);
		logic [63:0] word;
		logic signed [31:0] half;
		word = proj_mat[r * 2 + c / 2];
		half = (c % 2) ? word[31:0] : word[63:32];
		return longint'(half);
	endfunction

	function longint row_sum(int r, longint p [3]);
		longint s;
		s = coef(r, 3);
		for (int c = 0; c < 3; c++) s += (coef(r, c) * p[c]) >>> 16;
		return s;
	endfunction

	function void note_point(lppp_pkg::point_t pt);
		longint p [3];
		longint s0, s1, s2, col, row;
		bit ok;
		lppp_pkg::pixel_t px;
		p[0] = longint'(pt.point_x);
		p[1] = longint'(pt.point_y);
		p[2] = longint'(pt.point_z);
		s0 = row_sum(0, p);
		s1 = row_sum(1, p);
		s2 = row_sum(2, p);
		ok = 0;
		col = 0;
		row = 0;
		if (s2 != 0) begin
			col = s0 / s2;
			row = s1 / s2;
			ok = col >= 0 && col < img_w && row >= 0 && row < img_h;
		end
		if (!ok) begin
			col = 0;
			row = 0;
		end
		px.pixel_col = col[10:0];
		px.pixel_row = row[10:0];
		px.point_depth = pt.point_z;
		px.in_frame = ok;
		pixel_q.push_back(px);
	endfunction

	function void check_pixel(lppp_pkg::pixel_t got);
		lppp_pkg::pixel_t exp_px;
		if (pixel_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected pixel transaction %h", got);
			return;
		end
		exp_px = pixel_q.pop_front();
		if (got !== exp_px) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: col %0d/%0d row %0d/%0d depth %h/%h in_frame %b/%b",
					exp_px.pixel_col, got.pixel_col, exp_px.pixel_row, got.pixel_row,
					exp_px.point_depth, got.point_depth, exp_px.in_frame, got.in_frame);
		end
	endfunction

endclass

[tb/lidar_point_pixel_projection_tb.sv]
// ----------------------------------------------------------------------------
// lidar_point_pixel_projection_tb
// self-checking bench for the lidar point to pixel projection block
// ----------------------------------------------------------------------------
// programs several projection matrices over apb, streams directed and random
// points with random idling on both sides, and compares every pixel
// transaction against a class-based predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lidar_point_pixel_projection_tb;

	import lppp_pkg::*;

	localparam int LATENCY   = 32;
	localparam int WDOG_MAX  = 2000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	point_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	pixel_t out_data;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	lppp_scoreboard pix_sb;
	bit calm;          // no idling near the end of the run
	bit timed_out;
	int unsigned idle_cnt;

	always #5 clk = ~clk;

	lidar_point_pixel_projection dut (.*);

	// receiver side: random stall bursts, check each accepted transaction
	initial begin
		int burst;
		pix_sb = new(IMAGE_WIDTH_DEF, IMAGE_HEIGHT_DEF);
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) pix_sb.check_pixel(out_data);
			if (burst > 0) begin
				burst--;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 5) - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_MAX && !timed_out) begin
			timed_out = 1;
			$display("== FAIL ==");
			$finish;
		end
	end

	// apb write, setup phase then access phase
	task automatic apb_write(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		pix_sb.set_reg(idx, val);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic load_matrix(logic [63:0] m [6]);
		reg_idx_t idx;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = reg_idx_t'(i);
			apb_write(idx, m[i]);
		end
	endtask

	// one point transaction, with an optional leading gap
	task automatic send_point(point_t pt);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= pt;
		do @(posedge clk); while (!in_ready);
		pix_sb.note_point(pt);
	endtask

	// drop valid at the accepting edge so the last point goes in only once
	task automatic drain();
		in_valid <= 0;
		while (pix_sb.pixel_q.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [63:0] pack2(int a, int b);
		return {a[31:0], b[31:0]};
	endfunction

	function automatic int rnd_coord();
		case ($urandom_range(0, 3))
			0: return int'($urandom);
			1: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			2: return $urandom_range(32'h0001_0000, 32'h0040_0000);
			default: return int'($urandom_range(0, 7)) - 3;
		endcase
	endfunction

	function automatic point_t rnd_point();
		point_t pt;
		pt.point_x = rnd_coord();
		pt.point_y = rnd_coord();
		pt.point_z = ($urandom_range(0, 3) != 0) ?
			$urandom_range(32'h0000_8000, 32'h0080_0000) : rnd_coord();
		return pt;
	endfunction

	// camera-like matrix: fx, cx, fy, cy in row 0/1, z in row 2, random offsets
	function automatic void cam_matrix(ref logic [63:0] m [6]);
		int fx, fy, cx, cy;
		fx = $urandom_range(100, 2000) << 16;
		fy = $urandom_range(100, 2000) << 16;
		cx = $urandom_range(0, 1920) << 16;
		cy = $urandom_range(0, 1080) << 16;
		m[0] = pack2(fx, $urandom_range(0, 32'h1000) - 32'h800);
		m[1] = pack2(cx, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
		m[2] = pack2($urandom_range(0, 32'h1000) - 32'h800, fy);
		m[3] = pack2(cy, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
		m[4] = pack2($urandom_range(0, 32'h200) - 32'h100, $urandom_range(0, 32'h200) - 32'h100);
		m[5] = pack2(32'h0001_0000, $urandom_range(0, 32'h4000) - 32'h2000);
	endfunction

	initial begin
		logic [63:0] m [6];
		point_t pt;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// all-zero matrix after reset: zero divisor everywhere
		pt = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
		send_point(pt);
		pt = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_point(pt);
		drain();

		// extreme coefficients: most negative and most positive
		m = '{64'h8000_0000_7FFF_FFFF, 64'h8000_0000_7FFF_FFFF,
			64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_8000_0000,
			64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF};
		load_matrix(m);
		pt = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		send_point(pt);
		pt = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_point(pt);
		pt = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
		send_point(pt);
		pt = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF};
		send_point(pt);
		drain();

		// identity-like: col = x/z, row = y/z
		m = '{pack2(32'h0001_0000, 0), 64'h0, pack2(0, 32'h0001_0000), 64'h0,
			64'h0, pack2(32'h0001_0000, 0)};
		load_matrix(m);
		pt = '{32'h0001_0000 * 5, 32'h0001_0000 * 7, 32'h0001_0000};   // inside
		send_point(pt);
		pt = '{32'h0001_0000 * 1919, 32'h0001_0000 * 1079, 32'h0001_0000}; // last pixel
		send_point(pt);
		pt = '{32'h0001_0000 * 1920, 32'h0001_0000, 32'h0001_0000};    // column just out
		send_point(pt);
		pt = '{32'h0001_0000, 32'h0001_0000 * 1080, 32'h0001_0000};    // row just out
		send_point(pt);
		pt = '{-32'sh0000_8000, -32'sh0000_8000, 32'h0001_0000};       // small negative quotient
		send_point(pt);
		pt = '{-32'sh0001_0000 * 5, -32'sh0001_0000 * 5, -32'sh0001_0000}; // behind camera
		send_point(pt);
		pt = '{-32'sh0001_0000 * 2, 32'h0001_0000, 32'h0001_0000};     // negative column
		send_point(pt);
		pt = '{32'h0001_0000, 32'h0001_0000, 32'h0};                   // zero divisor
		send_point(pt);
		pt = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001};           // floor of tiny products
		send_point(pt);
		drain();

		// random phases, each with a fresh matrix; a drain between phases
		// doubles as the sender pause until every result has come
		for (int ph = 0; ph < 9; ph++) begin
			if (ph % 3 == 2)
				foreach (m[i]) m[i] = {$urandom, $urandom};
			else
				cam_matrix(m);
			load_matrix(m);
			if (ph == 8) calm = 1;
			for (int n = 0; n < 100; n++) begin
				pt = rnd_point();
				send_point(pt);
			end
			drain();
		end

		if (pix_sb.mismatches == 0 && pix_sb.pixel_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lppp_pkg.sv
hw/rtl/lppp_div.sv
hw/rtl/lidar_point_pixel_projection.sv
hw/rtl/lppp_checker.sv
tb/lppp_scoreboard.sv
tb/lidar_point_pixel_projection_tb.sv
